@@ src/adaptive_penalty_controller_macros.svh @@
// Assertion macros for the adaptive penalty controller checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ADAPTIVE_PENALTY_CONTROLLER_MACROS_SVH
`define ADAPTIVE_PENALTY_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define APC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define APC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/apc_pkg.sv @@
// Shared types and constants of the adaptive penalty controller.
// No dependencies.
`default_nettype none

package apc_pkg;

  localparam int KINDS       = 3;
  localparam int PEN_W       = 26;
  localparam int CNT_OUT_W   = 7;
  localparam int FACTOR_W    = 17;
  localparam int PROD_W      = PEN_W + FACTOR_W;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_ADJUST = 2'd1,
    OP_RELOAD = 2'd2,
    OP_IDLE   = 2'd3
  } opcode_e;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_DUR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_PACK = 2'd3;

  // Q10.16 penalty limits, Q1.16 factors, Q0.16 margin
  localparam logic [PEN_W-1:0]    PEN_CAP      = 26'd65536000;
  localparam logic [PEN_W-1:0]    PEN_FLOOR    = 26'd6554;
  localparam logic [PEN_W-1:0]    PEN_RESET    = 26'd6553600;
  localparam logic [FACTOR_W-1:0] UP_FACTOR    = 17'd78643;
  localparam logic [FACTOR_W-1:0] DOWN_FACTOR  = 17'd55706;
  localparam logic [12:0]         MARGIN       = 13'd3277;
  localparam logic [15:0]         TARGET_RESET = 16'd13107;

  // one record beat towards the window store
  typedef struct packed {
    logic             rec;
    logic [KINDS-1:0] ok;
  } rec_t;

endpackage

`default_nettype wire

@@ src/apc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module apc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/apc_window.sv @@
// Sliding feasibility windows: slot pointer, running counts and the window RAM.
// Depends on apc_pkg and apc_ram.
`default_nettype none

module apc_window #(
  parameter int WINDOW = 100,
  parameter int CW     = $clog2(WINDOW + 1),
  parameter int PW     = $clog2(WINDOW)
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire apc_pkg::rec_t                        rec_i,
  output logic      [apc_pkg::KINDS-1:0][CW-1:0]    cnt_q_o,
  output logic      [apc_pkg::KINDS-1:0][CW-1:0]    cnt_d_o
);

  logic [PW-1:0]                        ptr_q, ptr_d;
  logic                                 wrap_q, wrap_d;
  logic [apc_pkg::KINDS-1:0][CW-1:0]    cnt_q, cnt_d;
  logic [apc_pkg::KINDS-1:0]            ram_rdata;
  logic [apc_pkg::KINDS-1:0]            old_bits;
  logic                                 last_slot;

  // Slots are written in order, so before the first wrap the slot under the
  // pointer has never been written, so the wrap flag makes it count as all ones.
  assign old_bits  = wrap_q ? ram_rdata : '1;
  assign last_slot = (ptr_q == PW'(WINDOW - 1));

  always_comb begin
    ptr_d  = ptr_q;
    wrap_d = wrap_q;
    cnt_d  = cnt_q;
    if (rec_i.rec) begin
      ptr_d = last_slot ? '0 : ptr_q + 1'b1;
      if (last_slot) begin
        wrap_d = 1'b1;
      end
      for (int k = 0; k < apc_pkg::KINDS; k++) begin
        cnt_d[k] = cnt_q[k] - CW'(old_bits[k]) + CW'(rec_i.ok[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      wrap_q <= 1'b0;
      for (int k = 0; k < apc_pkg::KINDS; k++) begin
        cnt_q[k] <= CW'(WINDOW);
      end
    end else begin
      ptr_q  <= ptr_d;
      wrap_q <= wrap_d;
      cnt_q  <= cnt_d;
    end
  end

  // Read address runs one slot ahead so the old entry is ready on the beat
  // that overwrites it; the write never hits the slot being fetched.
  apc_ram #(
    .WIDTH (apc_pkg::KINDS),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (rec_i.rec),
    .waddr_i (ptr_q),
    .wdata_i (rec_i.ok),
    .raddr_i (ptr_d),
    .rdata_o (ram_rdata)
  );

  assign cnt_q_o = cnt_q;
  assign cnt_d_o = cnt_d;

endmodule

`default_nettype wire

@@ src/apc_scale.sv @@
// Penalty scaling for one constraint kind: band test, constant multiply, clamp.
// Depends on apc_pkg.
`default_nettype none

module apc_scale #(
  parameter int CW = 7,
  parameter int BW = CW + 19
) (
  input  wire logic        [apc_pkg::PEN_W-1:0] pen_i,
  input  wire logic        [CW-1:0]             cnt_i,
  input  wire logic signed [BW-1:0]             lower_i,
  input  wire logic signed [BW-1:0]             upper_i,
  output logic             [apc_pkg::PEN_W-1:0] pen_o
);

  logic signed [BW-1:0]                  frac;
  logic                                  below, above;
  logic        [apc_pkg::FACTOR_W-1:0]   factor;
  logic        [apc_pkg::PROD_W-1:0]     prod;
  logic        [apc_pkg::PEN_W:0]        scaled;

  assign frac  = $signed({{(BW - CW - 16){1'b0}}, cnt_i, 16'd0});
  assign below = (frac < lower_i) && (pen_i < apc_pkg::PEN_CAP);
  assign above = (frac > upper_i) && (pen_i > apc_pkg::PEN_FLOOR);

  // one shared multiplier, factor picked by the band test
  assign factor = below ? apc_pkg::UP_FACTOR : apc_pkg::DOWN_FACTOR;
  assign prod   = apc_pkg::PROD_W'(pen_i) * apc_pkg::PROD_W'(factor);
  assign scaled = prod[apc_pkg::PROD_W-1:16];

  always_comb begin
    if (below) begin
      pen_o = (scaled > (apc_pkg::PEN_W + 1)'(apc_pkg::PEN_CAP)) ?
              apc_pkg::PEN_CAP : scaled[apc_pkg::PEN_W-1:0];
    end else if (above) begin
      pen_o = (scaled < (apc_pkg::PEN_W + 1)'(apc_pkg::PEN_FLOOR)) ?
              apc_pkg::PEN_FLOOR : scaled[apc_pkg::PEN_W-1:0];
    end else begin
      pen_o = pen_i;
    end
  end

endmodule

`default_nettype wire

@@ src/adaptive_penalty_controller.sv @@
// Adaptive penalty controller top level: config registers, penalties, result register.
// Depends on apc_pkg, apc_window, apc_scale and apc_ram.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       s_axis_tdata  [7:0]
//   m_axis    out  m_axis_tvalid/tready       m_axis_tdata  [103:0]
//   cfg       in   cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// One beat per cycle in while s_axis_tready is high, one result per beat; the
// result sits in the output register the cycle after its beat is taken.
// Window RAM read runs one slot ahead of the pointer, so record beats flow
// every cycle while s_axis_tready is high; adjust uses one 26x17 multiplier per kind.
// Reset takes effect at once: unwritten window slots read as ones via a wrap flag.
// s_axis_tready drops only while a result is held and m_axis_tready is low.
`default_nettype none

module adaptive_penalty_controller #(
  parameter int WINDOW = 100
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // opcode[1:0], load_ok[2], duration_ok[3], pack_ok[4], zero[7:5]
  input  wire logic [apc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // capacity_penalty_out[25:0], duration_penalty_out[51:26],
  // pack_penalty_out[77:52], load_feasible_count[84:78],
  // duration_feasible_count[91:85], pack_feasible_count[98:92], zero[103:99]
  output logic      [apc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  wire logic                               cfg_we_i,
  input  wire logic [apc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [apc_pkg::PEN_W-1:0]          cfg_wdata_i
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int PW = $clog2(WINDOW);
  localparam int BW = CW + 19;

  localparam logic signed [BW-1:0] MARGIN_S  = BW'(apc_pkg::MARGIN);
  localparam logic signed [BW-1:0] WIN_S     = BW'(WINDOW);
  localparam logic signed [BW-1:0] LOWER_RST =
    BW'((int'(apc_pkg::TARGET_RESET) - int'(apc_pkg::MARGIN)) * WINDOW);
  localparam logic signed [BW-1:0] UPPER_RST =
    BW'((int'(apc_pkg::TARGET_RESET) + int'(apc_pkg::MARGIN)) * WINDOW);

  logic                                          in_acc;
  apc_pkg::opcode_e                              op;
  apc_pkg::rec_t                                 rec;
  logic [apc_pkg::KINDS-1:0][CW-1:0]             cnt_q, cnt_d;
  logic [apc_pkg::KINDS-1:0][apc_pkg::PEN_W-1:0] pen_q, pen_d, pen_scaled, init_q;
  logic [apc_pkg::KINDS-1:0][apc_pkg::CNT_OUT_W-1:0] cnt_out;
  logic signed [BW-1:0]                          lower_q, upper_q, tgt_s;
  logic                                          out_valid_q;
  logic [apc_pkg::OUT_TDATA_W-1:0]               out_data_q, out_data_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign op            = apc_pkg::opcode_e'(s_axis_tdata[1:0]);

  assign rec.rec = in_acc && (op == apc_pkg::OP_RECORD);
  assign rec.ok  = s_axis_tdata[4:2];

  apc_window #(
    .WINDOW (WINDOW),
    .CW     (CW),
    .PW     (PW)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec_i   (rec),
    .cnt_q_o (cnt_q),
    .cnt_d_o (cnt_d)
  );

  for (genvar k = 0; k < apc_pkg::KINDS; k++) begin : g_kind
    apc_scale #(
      .CW (CW),
      .BW (BW)
    ) u_scale (
      .pen_i   (pen_q[k]),
      .cnt_i   (cnt_q[k]),
      .lower_i (lower_q),
      .upper_i (upper_q),
      .pen_o   (pen_scaled[k])
    );
    // reported modulo 128
    assign cnt_out[k] = apc_pkg::CNT_OUT_W'(cnt_d[k]);
  end

  always_comb begin
    pen_d = pen_q;
    if (in_acc) begin
      case (op)
        apc_pkg::OP_ADJUST: pen_d = pen_scaled;
        apc_pkg::OP_RELOAD: pen_d = init_q;
        default:            pen_d = pen_q;
      endcase
    end
  end

  assign out_data_d = {5'd0, cnt_out[2], cnt_out[1], cnt_out[0],
                       pen_d[2], pen_d[1], pen_d[0]};

  // band limits are worked out once per target write
  assign tgt_s = $signed(BW'(cfg_wdata_i[15:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RST;
      upper_q <= UPPER_RST;
      init_q  <= {apc_pkg::KINDS{apc_pkg::PEN_RESET}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apc_pkg::REG_TARGET: begin
          lower_q <= (tgt_s - MARGIN_S) * WIN_S;
          upper_q <= (tgt_s + MARGIN_S) * WIN_S;
        end
        apc_pkg::REG_INIT_CAP:  init_q[0] <= cfg_wdata_i;
        apc_pkg::REG_INIT_DUR:  init_q[1] <= cfg_wdata_i;
        apc_pkg::REG_INIT_PACK: init_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q       <= {apc_pkg::KINDS{apc_pkg::PEN_RESET}};
      out_valid_q <= 1'b0;
    end else begin
      pen_q <= pen_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ src/apc_checker.sv @@
// Port-level checker for the adaptive penalty controller, bound to the top level.
// Depends on apc_pkg and adaptive_penalty_controller_macros.svh.
`default_nettype none
`include "adaptive_penalty_controller_macros.svh"

module apc_checker #(
  parameter int WINDOW = 100
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [apc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int CNT_MAX = (WINDOW > 127) ? 127 : WINDOW;

  logic in_beat, out_stall, cnts_in_range;

  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_stall     = m_axis_tvalid && !m_axis_tready;
  assign cnts_in_range = (m_axis_tdata[84:78] <= 7'(CNT_MAX)) &&
                         (m_axis_tdata[91:85] <= 7'(CNT_MAX)) &&
                         (m_axis_tdata[98:92] <= 7'(CNT_MAX));

  // held result must not change while the sink stalls
  `APC_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "held beat changed")

  // an empty output register never back-pressures the source
  `APC_ASSERT_IMPL(a_ready_empty, !m_axis_tvalid, s_axis_tready, "ready low with empty output")

  // every accepted beat shows a result on the next cycle
  `APC_ASSERT_NEXT(a_beat_result, in_beat, m_axis_tvalid, "accepted beat gave no result")

  // counts never exceed the window length
  `APC_ASSERT_IMPL(a_cnt_range, m_axis_tvalid, cnts_in_range, "feasible count above window")

endmodule

bind adaptive_penalty_controller apc_checker #(.WINDOW(WINDOW)) u_apc_checker (.*);

`default_nettype wire

@@ tb/tb_adaptive_penalty_controller.sv @@
// Self-checking testbench for adaptive_penalty_controller: a scoreboard class predicts
// the penalties and window counts per beat; plain tasks drive the stream and config ports.
// Depends on apc_pkg and the adaptive_penalty_controller RTL.
`timescale 1ns / 100ps

module tb_adaptive_penalty_controller;
  import apc_pkg::*;

  localparam int WINDOW      = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RES_W       = 3 * PEN_W + 3 * CNT_OUT_W;
  localparam int EXP_DEPTH   = 16;

  // ---------------------------------------------------------------------------
  // Scoreboard: own copy of windows, counts, penalties and config registers
  // ---------------------------------------------------------------------------
  class penalty_scoreboard;
    bit                window_bits [KINDS][WINDOW];
    int unsigned       oldest_slot;
    int unsigned       feasible_cnt [KINDS];
    logic [PEN_W-1:0]  penalty [KINDS];
    logic [PEN_W-1:0]  init_penalty [KINDS];
    logic [15:0]       target;
    logic [RES_W-1:0]  exp_fifo [EXP_DEPTH];
    int unsigned       exp_wr;
    int unsigned       exp_rd;
    int                mismatches;

    function new();
      target = TARGET_RESET;
      oldest_slot = 0;
      mismatches = 0;
      exp_wr = 0;
      exp_rd = 0;
      for (int k = 0; k < KINDS; k++) begin
        init_penalty[k] = PEN_RESET;
        penalty[k] = PEN_RESET;
        feasible_cnt[k] = WINDOW;
        for (int s = 0; s < WINDOW; s++) window_bits[k][s] = 1'b1;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PEN_W-1:0] val);
      case (idx)
        REG_TARGET:    target = val[15:0];
        REG_INIT_CAP:  init_penalty[0] = val;
        REG_INIT_DUR:  init_penalty[1] = val;
        REG_INIT_PACK: init_penalty[2] = val;
        default: ;
      endcase
    endfunction

    // one adjust step of a single kind; band tests are exact in Q16 * WINDOW
    function logic [PEN_W-1:0] rescaled_penalty(logic [PEN_W-1:0] pen, int unsigned cnt);
      longint frac, lo_bound, hi_bound, prod;
      frac     = longint'(cnt) * 65536;
      lo_bound = (longint'(target) - longint'(MARGIN)) * WINDOW;
      hi_bound = (longint'(target) + longint'(MARGIN)) * WINDOW;
      if (frac < lo_bound && pen < PEN_CAP) begin
        prod = (longint'(pen) * longint'(UP_FACTOR)) >> 16;
        if (prod > longint'(PEN_CAP)) prod = longint'(PEN_CAP);
        return prod[PEN_W-1:0];
      end
      if (frac > hi_bound && pen > PEN_FLOOR) begin
        prod = (longint'(pen) * longint'(DOWN_FACTOR)) >> 16;
        if (prod < longint'(PEN_FLOOR)) prod = longint'(PEN_FLOOR);
        return prod[PEN_W-1:0];
      end
      return pen;
    endfunction

    function void note_beat(opcode_e op, logic [KINDS-1:0] ok);
      logic [RES_W-1:0] res;
      int unsigned      slot;
      slot = oldest_slot % WINDOW;
      case (op)
        OP_RECORD: begin
          for (int k = 0; k < KINDS; k++) begin
            feasible_cnt[k] = feasible_cnt[k] - window_bits[k][slot] + ok[k];
            window_bits[k][slot] = ok[k];
          end
          oldest_slot = (slot + 1) % WINDOW;
        end
        OP_ADJUST:
          for (int k = 0; k < KINDS; k++)
            penalty[k] = rescaled_penalty(penalty[k], feasible_cnt[k]);
        OP_RELOAD:
          for (int k = 0; k < KINDS; k++) penalty[k] = init_penalty[k];
        default: ;  // idle opcode leaves everything as it is
      endcase
      res = '0;
      for (int k = 0; k < KINDS; k++) begin
        res[PEN_W*k +: PEN_W] = penalty[k];
        res[3*PEN_W + CNT_OUT_W*k +: CNT_OUT_W] = feasible_cnt[k][CNT_OUT_W-1:0];
      end
      exp_fifo[exp_wr % EXP_DEPTH] = res;
      exp_wr++;
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      string            field_name [6];
      logic [RES_W-1:0] exp_res, act_res;
      longint unsigned  exp_val, act_val, mask;
      int               lsb;
      field_name = '{"capacity_penalty_out", "duration_penalty_out", "pack_penalty_out",
                     "load_feasible_count", "duration_feasible_count",
                     "pack_feasible_count"};
      if (exp_wr == exp_rd) begin
        $display("%0t: result beat with nothing expected, got %h", $time, tdata);
        mismatches++;
        return;
      end
      exp_res = exp_fifo[exp_rd % EXP_DEPTH];
      exp_rd++;
      act_res = tdata[RES_W-1:0];
      for (int f = 0; f < 6; f++) begin
        lsb  = (f < 3) ? PEN_W * f : 3 * PEN_W + CNT_OUT_W * (f - 3);
        mask = (f < 3) ? ((64'd1 << PEN_W) - 1) : ((64'd1 << CNT_OUT_W) - 1);
        exp_val = longint'(exp_res >> lsb) & mask;
        act_val = longint'(act_res >> lsb) & mask;
        if (exp_val != act_val) begin
          $display("%0t: %s expected %0d, got %0d", $time, field_name[f], exp_val, act_val);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return int'(exp_wr - exp_rd);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT and clock
  // ---------------------------------------------------------------------------
  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [PEN_W-1:0]       cfg_wdata_i;

  penalty_scoreboard sb = new();
  int                idle_pct = 20;
  bit                quiet = 1'b0;
  int unsigned       cycles = 0;

  adaptive_penalty_controller #(
    .WINDOW(WINDOW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("adaptive_penalty_controller: mismatch");
      $finish;
    end
  end

  // both handshakes are sampled with their pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_beat(opcode_e'(s_axis_tdata[1:0]), s_axis_tdata[4:2]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata);
    end
  end

  // result side back-pressure
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks; each is entered and left at a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_beat(input opcode_e op, input logic [KINDS-1:0] ok);
    if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, ok, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PEN_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic set_config(input logic [PEN_W-1:0] tgt, input logic [PEN_W-1:0] cap,
                            input logic [PEN_W-1:0] dur, input logic [PEN_W-1:0] pack);
    put_reg(REG_TARGET, tgt);
    put_reg(REG_INIT_CAP, cap);
    put_reg(REG_INIT_DUR, dur);
    put_reg(REG_INIT_PACK, pack);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [PEN_W-1:0] pick_target();
    logic [PEN_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = 26'h000FFFF;
      2:       v = PEN_W'($urandom);  // upper bits are junk, dropped by the register
      default: v = PEN_W'($urandom_range(3000, 60000));
    endcase
    return v;
  endfunction

  function automatic logic [PEN_W-1:0] pick_penalty();
    logic [PEN_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = PEN_FLOOR;
      1:       v = PEN_CAP;
      2:       v = PEN_W'($urandom);  // may be outside the legal Q10.16 range
      default: v = PEN_W'($urandom_range(6554, 65536000));
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int               bias [KINDS];
    int               r;
    opcode_e          op;
    logic [KINDS-1:0] ok;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_TARGET;
    cfg_wdata_i   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: full windows sit above the band, so adjust shrinks
    send_beat(OP_ADJUST, 3'b000);
    send_beat(OP_IDLE, 3'b111);
    send_beat(OP_RELOAD, 3'b101);
    send_beat(OP_RECORD, 3'b000);
    send_beat(OP_RECORD, 3'b111);
    send_beat(OP_RECORD, 3'b101);
    send_beat(OP_RECORD, 3'b010);
    send_beat(OP_ADJUST, 3'b111);
    drain_results();

    // target near one: window counts of 94 or less sit below the band; penalties above, at and just under the cap
    set_config(26'h3FFFFFF, 26'h3FFFFFF, PEN_CAP, PEN_CAP - 1);
    send_beat(OP_RELOAD, 3'b010);
    repeat (6) send_beat(OP_RECORD, 3'b000);
    send_beat(OP_ADJUST, 3'b000);
    send_beat(OP_ADJUST, 3'b101);
    drain_results();

    // target at zero: lower bound negative; penalties below, at and just over the floor
    set_config('0, '0, PEN_FLOOR, PEN_FLOOR + 1);
    send_beat(OP_RELOAD, 3'b000);
    send_beat(OP_ADJUST, 3'b110);
    send_beat(OP_IDLE, 3'b000);
    send_beat(OP_ADJUST, 3'b011);
    drain_results();

    // random phases, each with its own settings, idling and feasibility bias
    for (int p = 0; p < 6; p++) begin
      quiet = (p == 5);
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        2:       idle_pct = 30;
        default: idle_pct = 60;
      endcase
      set_config(pick_target(), pick_penalty(), pick_penalty(), pick_penalty());
      for (int k = 0; k < KINDS; k++) begin
        case ($urandom_range(0, 3))
          0:       bias[k] = 0;
          1:       bias[k] = 100;
          default: bias[k] = $urandom_range(0, 100);
        endcase
      end
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70)      op = OP_RECORD;
        else if (r < 88) op = OP_ADJUST;
        else if (r < 95) op = OP_RELOAD;
        else             op = OP_IDLE;
        if (op == OP_RECORD) begin
          for (int k = 0; k < KINDS; k++) ok[k] = ($urandom_range(0, 99) < bias[k]);
        end else begin
          ok = KINDS'($urandom);
        end
        send_beat(op, ok);
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0)
      $display("%0t: %0d results never arrived", $time, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("adaptive_penalty_controller: match");
    end else begin
      $display("adaptive_penalty_controller: mismatch");
    end
    $finish;
  end

endmodule
